### rtl/szsd_pkg.sv
// szsd_pkg: shared constants and types of the sliding z-score spike detector
// no dependencies; imported by every module of the block
package szsd_pkg;

    localparam int SAMPLE_W        = 16;   // signed sample width
    localparam int INDEX_W         = 24;   // sample index width
    localparam int K_W             = 8;    // threshold multiplier width
    localparam int K_FRAC_W        = 4;    // fraction bits of the multiplier
    localparam int HALF_WINDOW_DEF = 10;   // samples on each side of the center
    localparam int JOB_DEPTH       = 2;    // queue between front and back
    localparam int RES_DEPTH       = 4;    // result queue

    localparam logic [K_W-1:0]     K_RESET = K_W'(48);   // 3.0 in q4.4
    localparam logic [INDEX_W-1:0] POS_MAX = {INDEX_W{1'b1}};

    // occupancy flags of a queue
    typedef struct packed {
        logic empty;
        logic full;
        logic afull;    // at most one entry free
    } t_fifo_stat;

endpackage

### rtl/szsd_fifo.sv
// szsd_fifo: small register queue with occupancy flags
// depends on szsd_pkg (t_fifo_stat)
module szsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_data,
    output szsd_pkg::t_fifo_stat   o_stat
);
    import szsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.afull = (r_cnt >= CNT_W'(DEPTH - 1));

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/szsd_front.sv
// szsd_front: takes samples, keeps the window memory and running sums, queues tests
// depends on szsd_pkg
module szsd_front #(
    parameter int HALF_WINDOW = szsd_pkg::HALF_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [szsd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_first_of_series,
    output logic                                o_job_push,
    output logic [2*szsd_pkg::SAMPLE_W + 2*szsd_pkg::SAMPLE_W - 2
                  + 2*$clog2(2*HALF_WINDOW+1) + szsd_pkg::INDEX_W - 1:0] o_job_data,
    input  szsd_pkg::t_fifo_stat                i_job_stat
);
    import szsd_pkg::*;

    localparam int N      = 2 * HALF_WINDOW + 1;
    localparam int LOG_N  = $clog2(N);
    localparam int SLOT_W = LOG_N;
    localparam int FILL_W = $clog2(N + 1);
    localparam int SUM_W  = SAMPLE_W + LOG_N;
    localparam int SQ_W   = 2 * SAMPLE_W - 1;
    localparam int Q_W    = 2 * SAMPLE_W - 2 + LOG_N;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SUM_W-1:0]    sum;
        logic [Q_W-1:0]             sqsum;
        logic [INDEX_W-1:0]         index;
    } t_job;

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_UPD} t_front_state;

    t_front_state               r_state;
    logic [SLOT_W-1:0]          r_slot;
    logic [FILL_W-1:0]          r_fill;
    logic [INDEX_W-1:0]         r_pos;
    logic signed [SUM_W-1:0]    r_sum;
    logic [Q_W-1:0]             r_sqsum;
    logic                       r_sub;
    logic                       r_emit;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_old;
    logic signed [SAMPLE_W-1:0] r_ctr;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_old;
    logic signed [SAMPLE_W-1:0] r_mem [N];

    logic                         accept;
    logic [SLOT_W-1:0]            slot_eff;
    logic [FILL_W-1:0]            fill_eff;
    logic [INDEX_W-1:0]           pos_eff;
    logic                         win_full;
    logic [SLOT_W:0]              ctr_sum;
    logic [SLOT_W-1:0]            ctr_addr;
    logic [SLOT_W-1:0]            n_slot;
    logic [FILL_W-1:0]            n_fill;
    logic [INDEX_W-1:0]           n_pos;
    logic signed [2*SAMPLE_W-1:0] sq_x_full;
    logic signed [2*SAMPLE_W-1:0] sq_old_full;
    logic signed [SUM_W-1:0]      n_sum;
    logic [Q_W-1:0]               n_sqsum;
    t_job                         job;

    assign o_full = (r_state != F_IDLE) || i_job_stat.full;
    assign accept = i_push && !o_full;

    // a new series starts from an empty window at slot zero
    assign slot_eff = i_first_of_series ? '0 : r_slot;
    assign fill_eff = i_first_of_series ? '0 : r_fill;
    assign pos_eff  = i_first_of_series ? '0 : r_pos;
    assign win_full = (fill_eff == FILL_W'(N));

    // center is HALF_WINDOW entries behind the new sample, i.e. HALF_WINDOW+1 past its slot
    assign ctr_sum  = (SLOT_W+1)'(slot_eff) + (SLOT_W+1)'(HALF_WINDOW + 1);
    assign ctr_addr = (ctr_sum >= (SLOT_W+1)'(N)) ? SLOT_W'(ctr_sum - (SLOT_W+1)'(N))
                                                  : SLOT_W'(ctr_sum);
    assign n_slot   = (slot_eff == SLOT_W'(N - 1)) ? '0 : slot_eff + 1'b1;
    assign n_fill   = win_full ? fill_eff : fill_eff + 1'b1;
    assign n_pos    = (pos_eff == POS_MAX) ? pos_eff : pos_eff + 1'b1;

    assign sq_x_full   = r_x * r_x;
    assign sq_old_full = r_old * r_old;

    assign n_sum   = r_sum - (r_sub ? SUM_W'(r_old) : SUM_W'(0)) + SUM_W'(r_x);
    assign n_sqsum = r_sqsum - (r_sub ? Q_W'(r_sq_old) : Q_W'(0)) + Q_W'(r_sq_x);

    assign job.center = r_ctr;
    assign job.sum    = r_sum;
    assign job.sqsum  = n_sqsum;
    assign job.index  = r_pos - INDEX_W'(HALF_WINDOW + 1);

    assign o_job_push = (r_state == F_UPD) && r_emit;
    assign o_job_data = job;

    // sequence: read memory, square, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_slot  <= '0;
            r_fill  <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_sub   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_SQ;
                        r_slot  <= n_slot;
                        r_fill  <= n_fill;
                        r_pos   <= n_pos;
                        r_sub   <= win_full;
                        r_emit  <= (n_fill == FILL_W'(N));
                        if (i_first_of_series) begin
                            r_sum   <= '0;
                            r_sqsum <= '0;
                        end
                    end
                end
                F_SQ: begin
                    r_state <= F_UPD;
                    r_sum   <= n_sum;
                end
                F_UPD: begin
                    r_state <= F_IDLE;
                    r_sqsum <= n_sqsum;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x            <= i_sample;
            r_old          <= r_mem[slot_eff];
            r_ctr          <= r_mem[ctr_addr];
            r_mem[slot_eff] <= i_sample;
        end
        if (r_state == F_SQ) begin
            r_sq_x   <= sq_x_full[SQ_W-1:0];
            r_sq_old <= sq_old_full[SQ_W-1:0];
        end
    end

endmodule

### rtl/szsd_back.sv
// szsd_back: exact integer z-score test of queued windows, taking the next one in the compare step
// depends on szsd_pkg
module szsd_back #(
    parameter int HALF_WINDOW = szsd_pkg::HALF_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [szsd_pkg::K_W-1:0]            i_threshold_k,
    input  szsd_pkg::t_fifo_stat                i_job_stat,
    output logic                                o_job_pop,
    input  logic [2*szsd_pkg::SAMPLE_W + 2*szsd_pkg::SAMPLE_W - 2
                  + 2*$clog2(2*HALF_WINDOW+1) + szsd_pkg::INDEX_W - 1:0] i_job_data,
    input  szsd_pkg::t_fifo_stat                i_res_stat,
    output logic                                o_res_push,
    output logic [szsd_pkg::INDEX_W-1:0]        o_res_index
);
    import szsd_pkg::*;

    localparam int N      = 2 * HALF_WINDOW + 1;
    localparam int LOG_N  = $clog2(N);
    localparam int SUM_W  = SAMPLE_W + LOG_N;
    localparam int Q_W    = 2 * SAMPLE_W - 2 + LOG_N;
    localparam int D_W    = SAMPLE_W + 1 + LOG_N;
    localparam int DD_W   = 2 * (D_W - 1);
    localparam int VAR_W  = 2 * SUM_W - 2;
    localparam int KK_W   = 2 * K_W;
    localparam int LHS_W  = DD_W + 2 * K_FRAC_W;
    localparam int RHS_W  = VAR_W + KK_W;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SUM_W-1:0]    sum;
        logic [Q_W-1:0]             sqsum;
        logic [INDEX_W-1:0]         index;
    } t_job;

    typedef enum logic [1:0] {B_IDLE, B_VAR, B_RHS, B_CMP} t_back_state;

    t_back_state          r_state;
    logic                 r_dpos;
    logic [D_W-2:0]       r_dmag;
    logic [VAR_W-1:0]     r_nq;
    logic [VAR_W-1:0]     r_ss;
    logic [KK_W-1:0]      r_kk;
    logic [INDEX_W-1:0]   r_idx;
    logic [VAR_W-1:0]     r_var;
    logic [DD_W-1:0]      r_dd;
    logic [RHS_W-1:0]     r_rhs;
    logic [LHS_W-1:0]     r_lhs;

    t_job                    job;
    logic                    take;
    logic signed [D_W-1:0]   n_d;
    logic signed [2*SUM_W-1:0] ss_full;
    logic                    pass;

    assign job = i_job_data;

    // a result is still owed while in the compare step, so ask for two free slots
    assign take = !i_job_stat.empty &&
                  (((r_state == B_IDLE) && !i_res_stat.full) ||
                   ((r_state == B_CMP) && !i_res_stat.afull));
    assign o_job_pop = take;

    assign n_d     = D_W'(job.center) * D_W'(N) - D_W'(job.sum);
    assign ss_full = job.sum * job.sum;

    assign pass        = r_dpos && (CMP_W'(r_lhs) > CMP_W'(r_rhs));
    assign o_res_push  = (r_state == B_CMP) && pass;
    assign o_res_index = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE:  r_state <= take ? B_VAR : B_IDLE;
                B_VAR:   r_state <= B_RHS;
                B_RHS:   r_state <= B_CMP;
                B_CMP:   r_state <= take ? B_VAR : B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dpos <= !n_d[D_W-1] && (n_d != '0);
            r_dmag <= n_d[D_W-2:0];
            r_nq   <= VAR_W'(job.sqsum) * VAR_W'(N);
            r_ss   <= ss_full[VAR_W-1:0];
            r_kk   <= KK_W'(i_threshold_k) * KK_W'(i_threshold_k);
            r_idx  <= job.index;
        end
        if (r_state == B_VAR) begin
            r_var <= r_nq - r_ss;
            r_dd  <= DD_W'(r_dmag) * DD_W'(r_dmag);
        end
        if (r_state == B_RHS) begin
            r_rhs <= RHS_W'(r_kk) * RHS_W'(r_var);
            r_lhs <= {r_dd, {(2*K_FRAC_W){1'b0}}};
        end
    end

endmodule

### rtl/sliding_zscore_spike_detector.sv
// sliding_zscore_spike_detector: top level of the sliding z-score spike detector
// depends on szsd_pkg, szsd_fifo, szsd_front, szsd_back
//
// takes signed 16-bit samples and reports the index of the window center whenever
// the center sample y lies more than k population standard deviations above the mean
// of the centered window of N = 2*HALF_WINDOW+1 samples; the test is exact:
// D = N*y - S > 0 and D*D*256 > k*k*(N*Q - S*S), with k unsigned q4.4 (reset 3.0).
// first_of_series restarts the window and the index, so a series gives no result
// until N samples have arrived; the index stops at 2^24-2-HALF_WINDOW. the front sequencer
// takes a sample only when idle and not held by a full job queue, then steps through
// window memory read, squaring and sum update; the back sequencer steps each window
// through products, variance and compare and takes the next one in the compare step.
// a result passes the front steps, the job queue, the back steps and the result queue
// before it is on the ports. a short queue between front and back and a 4-word result
// queue hold words while either side stalls, until they fill. the window memory needs
// no clearing: only entries written in the current series are used.
module sliding_zscore_spike_detector #(
    parameter int HALF_WINDOW = szsd_pkg::HALF_WINDOW_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample side, queue-like
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [szsd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_first_of_series,
    // result side, queue-like
    output logic                                 empty,
    input  logic                                 pop,
    output logic [szsd_pkg::INDEX_W-1:0]         o_spike_index,
    // threshold register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [szsd_pkg::K_W-1:0]             i_cfg_data
);
    import szsd_pkg::*;

    localparam int LOG_N = $clog2(2 * HALF_WINDOW + 1);
    // center sample, running sum, running square sum, index
    localparam int JOB_W = SAMPLE_W + (SAMPLE_W + LOG_N) + (2 * SAMPLE_W - 2 + LOG_N)
                           + INDEX_W;

    logic [K_W-1:0]     r_threshold_k;

    logic               job_push;
    logic [JOB_W-1:0]   job_wdata;
    logic               job_pop;
    logic [JOB_W-1:0]   job_rdata;
    t_fifo_stat         job_stat;

    logic               res_push;
    logic [INDEX_W-1:0] res_wdata;
    t_fifo_stat         res_stat;

    // threshold register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_k <= K_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold_k <= i_cfg_data;
        end
    end

    // front: window memory, running sums, fill and index counters
    szsd_front #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_sample          (i_sample),
        .i_first_of_series (i_first_of_series),
        .o_job_push        (job_push),
        .o_job_data        (job_wdata),
        .i_job_stat        (job_stat)
    );

    // windows waiting for the test
    szsd_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_wdata),
        .i_pop   (job_pop),
        .o_data  (job_rdata),
        .o_stat  (job_stat)
    );

    // back: deviation test
    szsd_back #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_threshold_k (r_threshold_k),
        .i_job_stat    (job_stat),
        .o_job_pop     (job_pop),
        .i_job_data    (job_rdata),
        .i_res_stat    (res_stat),
        .o_res_push    (res_push),
        .o_res_index   (res_wdata)
    );

    // spike indexes waiting for the consumer
    szsd_fifo #(
        .WIDTH (INDEX_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .i_pop   (pop),
        .o_data  (o_spike_index),
        .o_stat  (res_stat)
    );

    assign empty = res_stat.empty;

endmodule

### rtl/szsd_checker.sv
// szsd_checker: port-level assertions for the spike detector, bound to the top level
// depends on szsd_pkg and sliding_zscore_spike_detector
module szsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [szsd_pkg::INDEX_W-1:0]  o_spike_index
);
    import szsd_pkg::*;

    // reset leaves both queues open and nothing to deliver
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not clear after reset");

    // the front sequencer stays busy through its squaring and update steps after taking a word
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full ##1 full)
        else $error("sample side reopened too early");

    // a waiting result stays put until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_spike_index))
        else $error("waiting result changed or vanished");

endmodule

bind sliding_zscore_spike_detector szsd_checker u_szsd_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for sliding_zscore_spike_detector, with its own window predictor
// depends on szsd_pkg and the sliding_zscore_spike_detector rtl, nothing else
module testbench;
    import szsd_pkg::*;

    localparam int HALF          = HALF_WINDOW_DEF;
    localparam int WIN_N         = 2 * HALF + 1;
    localparam int SETTLE_CYCLES = 40;       // latency plus inner queue drain
    localparam int RX_HOLD       = 600;      // long result-side hold-off
    localparam int TIMEOUT_CYCLES = 1_000_000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       first;
        int                         gap;     // idle cycles before the word is offered
    } t_sample_word;

    typedef enum {SER_NOISE, SER_FULL, SER_FLAT, SER_SHORT} t_series_kind;

    // dut ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_first_of_series = 1'b0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [INDEX_W-1:0]         o_spike_index;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [K_W-1:0]             i_cfg_data = '0;

    // stimulus and expected spikes
    t_sample_word       sample_q[$];
    logic [INDEX_W-1:0] spike_due_q[$];
    int                 tx_gap_cnt = 0;
    int                 tx_run_left = 0;
    bit                 tx_run_tight = 1'b0;
    int                 rx_wait_left = 0;
    int                 rx_run_left = 0;
    bit                 rx_run_tight = 1'b0;
    int                 rx_hold_left = 0;
    bit                 rx_hold_req = 1'b0;
    int                 fail_count = 0;

    // predictor copy of the window and the threshold
    longint             win_mem [WIN_N];
    int unsigned        wr_slot = 0;
    int unsigned        fill_n = 0;
    longint             win_sum = 0;
    longint             win_sq = 0;
    logic [INDEX_W-1:0] pos_n = '0;
    logic [K_W-1:0]     k_q = K_RESET;

    sliding_zscore_spike_detector #(
        .HALF_WINDOW(HALF)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_sample         (i_sample),
        .i_first_of_series(i_first_of_series),
        .empty            (empty),
        .pop              (pop),
        .o_spike_index    (o_spike_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // idle cycles per word: each stretch of words has either random gaps or none
    function automatic int draw_gap(inout int run_left, inout bit run_tight);
        if (run_left == 0) begin
            run_left  = $urandom_range(10, 60);
            run_tight = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return run_tight ? 0 : $urandom_range(0, 19);
    endfunction

    // update the window with one accepted sample and queue the spike it reveals, if any
    task automatic predict_sample(input logic signed [SAMPLE_W-1:0] x, input logic first);
        int unsigned center;
        longint      old, y, dev, var_term, lhs, rhs;
        if (first) begin
            // new series: window, sums and index restart with this sample
            wr_slot = 0;
            fill_n  = 0;
            win_sum = 0;
            win_sq  = 0;
            pos_n   = '0;
        end
        if (fill_n >= WIN_N) begin
            old      = win_mem[wr_slot];
            win_sum -= old;
            win_sq  -= old * old;
        end else begin
            fill_n++;
        end
        win_mem[wr_slot] = longint'(x);
        win_sum += longint'(x);
        win_sq  += longint'(x) * longint'(x);
        wr_slot  = (wr_slot + 1) % WIN_N;
        if (pos_n != POS_MAX)
            pos_n++;
        // window not full yet
        if (fill_n < WIN_N)
            return;
        // center lies HALF words behind the newest one
        center = (wr_slot + WIN_N - 1 - HALF) % WIN_N;
        y      = win_mem[center];
        dev    = WIN_N * y - win_sum;
        // center at or below the mean, flat window included
        if (dev <= 0)
            return;
        var_term = WIN_N * win_sq - win_sum * win_sum;
        lhs      = (dev * dev) << 8;
        rhs      = longint'(k_q) * longint'(k_q) * var_term;
        if (lhs > rhs)
            spike_due_q.insert(spike_due_q.size(), INDEX_W'(pos_n - 1 - HALF));
    endtask

    function automatic void queue_word(input int value, input bit first, input bit gapless);
        t_sample_word w;
        w.value = SAMPLE_W'(value);
        w.first = first;
        w.gap   = gapless ? 0 : draw_gap(tx_run_left, tx_run_tight);
        sample_q.insert(sample_q.size(), w);
    endfunction

    // one series of the given shape; returns how many words it queued
    function automatic int queue_series(input t_series_kind kind, input bit gapless);
        int len, base, amp, v, spike_at, i;
        case (kind)
            SER_NOISE: len = $urandom_range(22, 90);
            SER_FULL:  len = $urandom_range(21, 40);
            SER_FLAT:  len = $urandom_range(21, 30);
            default:   len = $urandom_range(1, 20);
        endcase
        base = int'($urandom_range(0, 40000)) - 20000;
        amp  = $urandom_range(1, 3000);
        case ($urandom_range(0, 3))
            0:       base = -32768;
            1:       base = 32767;
            2:       base = 0;
            default: ;
        endcase
        spike_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, len - 1) : -1;
        for (i = 0; i < len; i++) begin
            case (kind)
                SER_NOISE: begin
                    v = base + int'($urandom_range(0, 2 * amp)) - amp;
                    // occasional burst, mostly upward
                    if ($urandom_range(0, 11) == 0)
                        v += (($urandom_range(0, 4) == 0) ? -1 : 1) * amp
                             * int'($urandom_range(3, 12));
                end
                SER_FLAT: begin
                    v = base;
                    if (i == spike_at)
                        v = int'($urandom_range(0, 65535)) - 32768;
                end
                default: v = int'($urandom_range(0, 65535)) - 32768;
            endcase
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            // rare restart inside a noisy series breaks the window
            queue_word(v, (i == 0) || (kind == SER_NOISE && $urandom_range(0, 59) == 0), gapless);
        end
        return len;
    endfunction

    task automatic queue_random(input int budget, input bit gapless);
        int queued, r;
        queued = 0;
        while (queued < budget) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                queued += queue_series(SER_NOISE, gapless);
            else if (r < 75)
                queued += queue_series(SER_FULL, gapless);
            else if (r < 87)
                queued += queue_series(SER_FLAT, gapless);
            else
                queued += queue_series(SER_SHORT, gapless);
        end
    endtask

    // sender waits until every word is taken and every spike has come, then lets
    // the pipeline run dry in case the last words produced nothing
    task automatic drain_and_settle();
        do
            @(negedge i_clk);
        while (sample_q.size() != 0 || push || spike_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [K_W-1:0] k);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        k_q = k;
        @(negedge i_clk);
    endtask

    // sample side: offers the queued words, predicts on every accepted one
    always @(posedge i_clk) begin : sample_side
        t_sample_word nxt;
        if (!i_rst_n) begin
            push       <= 1'b0;
            tx_gap_cnt <= 0;
        end else begin
            if (push && !full)
                predict_sample(i_sample, i_first_of_series);
            // a word refused by full stays on the ports untouched
            if (!push || !full) begin
                if (sample_q.size() != 0 && tx_gap_cnt >= sample_q[0].gap) begin
                    nxt = sample_q.pop_front();
                    i_sample          <= nxt.value;
                    i_first_of_series <= nxt.first;
                    push              <= 1'b1;
                    tx_gap_cnt        <= 0;
                end else begin
                    push <= 1'b0;
                    if (sample_q.size() != 0)
                        tx_gap_cnt <= tx_gap_cnt + 1;
                end
            end
        end
    end

    // long hold-off of the result side, counted on its own
    always @(posedge i_clk) begin
        if (rx_hold_req)
            rx_hold_left <= RX_HOLD;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // result side: pops with random gaps, compares each word with the oldest expected spike
    always @(posedge i_clk) begin : result_side
        logic [INDEX_W-1:0] want;
        int                 wait_next;
        if (!i_rst_n) begin
            pop          <= 1'b0;
            rx_wait_left <= 0;
        end else begin
            wait_next = (rx_wait_left != 0) ? rx_wait_left - 1 : 0;
            if (pop && !empty) begin
                if (spike_due_q.size() == 0) begin
                    $error("spike_index: expected none, actual %0d", o_spike_index);
                    fail_count++;
                end else begin
                    want = spike_due_q.pop_front();
                    if (o_spike_index !== want) begin
                        $error("spike_index: expected %0d, actual %0d", want, o_spike_index);
                        fail_count++;
                    end
                end
                wait_next = draw_gap(rx_run_left, rx_run_tight);
            end
            rx_wait_left <= wait_next;
            pop          <= (wait_next == 0) && (rx_hold_left == 0) && !rx_hold_req;
        end
    end

    initial begin : stimulus
        int i;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed series at the reset threshold: one full-scale spike at the first center,
        // the most negative sample as the second word, small alternating values elsewhere
        for (i = 0; i < WIN_N; i++) begin
            if (i == 1)
                queue_word(-32768, 1'b0, 1'b0);
            else if (i == HALF)
                queue_word(32767, 1'b0, 1'b0);
            else
                queue_word((i % 2 == 0) ? 1 : -1, i == 0, 1'b0);
        end
        // restarts before the window fills: no results
        queue_word(32767, 1'b1, 1'b0);
        queue_word(-32768, 1'b0, 1'b0);
        queue_word(5, 1'b1, 1'b0);
        queue_word(-5, 1'b0, 1'b0);
        queue_random(250, 1'b0);
        drain_and_settle();

        // zero multiplier: any center above the mean is a spike, so results pile up
        // while the result side holds off and the sample side keeps pushing
        write_threshold('0);
        rx_hold_req = 1'b1;
        queue_random(160, 1'b1);
        @(negedge i_clk);
        rx_hold_req = 1'b0;
        queue_random(150, 1'b0);
        drain_and_settle();

        // largest multiplier, beyond reach for this window length
        write_threshold({K_W{1'b1}});
        queue_random(250, 1'b0);
        drain_and_settle();

        // one deviation
        write_threshold(K_W'(16));
        queue_random(300, 1'b0);
        drain_and_settle();

        // random multiplier around the reachable limit, with a mid-phase pause
        write_threshold(K_W'($urandom_range(20, 70)));
        queue_random(120, 1'b0);
        drain_and_settle();
        queue_random(130, 1'b0);
        drain_and_settle();

        // back to the reset value
        write_threshold(K_RESET);
        queue_random(365, 1'b0);
        drain_and_settle();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
